FILE: src/upd_pkg.sv
// ----------------------------------------------------------------------------
// URL percent decoder package
// Character codes, escape phase encoding, decode burst type and hex helper.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharQmark = 8'h3F;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [3:0] HexLetterOffset = 4'd9;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhPct  = 2'd1,
    PhHex  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] bytes;
  } burst_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = '0;
    if (c inside {[8'h30:8'h39]}) begin
      res = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      res = {1'b1, c[3:0] + HexLetterOffset};
    end
    return res;
  endfunction

endpackage

FILE: src/url_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// URL percent decoder - top level
// Streaming percent-escape decoder with valid/ready input and output.
// ----------------------------------------------------------------------------
// One encoded byte is accepted per cycle unless the output stalls; each
// byte yields zero to three decoded words, delivered one per cycle from a
// result register while out_ready_i is high. Input is taken while no result
// word is pending or its final word is taken, so a bad escape's burst of
// two or three words holds the input. The first result word is presented
// in the cycle after the input accept. Writing cfg_wdata_i with
// cfg_we_i selects whether '+' decodes to a space (reset value 1).
module url_percent_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       string_end_o
);

  upd_pkg::burst_t burst;
  logic            in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  upd_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .burst_o     (burst)
  );

  upd_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .burst_i      (burst),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

endmodule

FILE: src/upd_dec.sv
// ----------------------------------------------------------------------------
// URL percent decoder - escape decoder
// Holds escape phase, held digit and config bit; maps one input word to a
// burst of zero to three result bytes.
// ----------------------------------------------------------------------------
module upd_dec (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_fire_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  output upd_pkg::burst_t burst_o
);

  upd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic            p2s_q;

  logic [4:0] b_hex;
  logic [4:0] held_hex;
  logic       opens;
  logic       sp_emit;
  logic [7:0] sp_byte;

  assign b_hex    = upd_pkg::hex_decode(in_byte_i);
  assign held_hex = upd_pkg::hex_decode(held_q);
  assign opens    = (in_byte_i == upd_pkg::CharPct) && !in_last_i;
  assign sp_emit  = !opens;

  always_comb begin
    if (in_byte_i == upd_pkg::CharPct) begin
      sp_byte = upd_pkg::CharQmark;
    end else if (in_byte_i == upd_pkg::CharPlus && p2s_q) begin
      sp_byte = upd_pkg::CharSpace;
    end else begin
      sp_byte = in_byte_i;
    end
  end

  always_comb begin
    burst_o       = '0;
    burst_o.last  = in_last_i;
    held_d        = held_q;
    phase_d       = opens ? upd_pkg::PhPct : upd_pkg::PhIdle;
    case (phase_q)
      upd_pkg::PhPct: begin
        if (b_hex[4] && !in_last_i) begin
          held_d  = in_byte_i;
          phase_d = upd_pkg::PhHex;
        end else begin
          burst_o.bytes[0] = upd_pkg::CharQmark;
          burst_o.bytes[1] = sp_byte;
          burst_o.cnt      = sp_emit ? 2'd2 : 2'd1;
        end
      end
      upd_pkg::PhHex: begin
        if (b_hex[4]) begin
          burst_o.bytes[0] = {held_hex[3:0], b_hex[3:0]};
          burst_o.cnt      = 2'd1;
          phase_d          = upd_pkg::PhIdle;
        end else begin
          burst_o.bytes[0] = upd_pkg::CharQmark;
          burst_o.bytes[1] = held_q;
          burst_o.bytes[2] = sp_byte;
          burst_o.cnt      = sp_emit ? 2'd3 : 2'd2;
        end
      end
      default: begin
        burst_o.bytes[0] = sp_byte;
        burst_o.cnt      = {1'b0, sp_emit};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PhIdle;
      held_q  <= '0;
      p2s_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        p2s_q <= cfg_wdata_i;
      end
      if (in_fire_i) begin
        phase_q <= phase_d;
        held_q  <= held_d;
      end
    end
  end

endmodule

FILE: src/upd_obuf.sv
// ----------------------------------------------------------------------------
// URL percent decoder - result buffer
// Registers one decode burst and hands its bytes out one word at a time.
// ----------------------------------------------------------------------------
module upd_obuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  upd_pkg::burst_t burst_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_end_o,
  output logic            string_end_o
);

  logic [2:0][7:0] bytes_q;
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      pos_q, pos_d;
  logic            last_q;
  logic            in_fire;
  logic            out_fire;
  logic            on_final;

  assign out_valid_o  = (pos_q != cnt_q);
  assign on_final     = (pos_q + 2'd1 == cnt_q);
  assign out_fire     = out_valid_o && out_ready_i;
  assign in_ready_o   = !out_valid_o || (out_ready_i && on_final);
  assign in_fire      = in_valid_i && in_ready_o;
  assign run_end_o    = on_final;
  assign string_end_o = on_final && last_q;

  always_comb begin
    case (pos_q)
      2'd0:    out_byte_o = bytes_q[0];
      2'd1:    out_byte_o = bytes_q[1];
      default: out_byte_o = bytes_q[2];
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (in_fire) begin
      cnt_d = burst_i.cnt;
      pos_d = '0;
    end else if (out_fire) begin
      pos_d = pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bytes_q <= burst_i.bytes;
      last_q  <= burst_i.last;
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= cnt_q) else $error("result position past burst count");

  a_ready_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && out_valid_o) |-> on_final)
    else $error("input taken with more than one result pending");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !on_final) |=> (out_valid_o && $stable(cnt_q)))
    else $error("burst broken before its final word");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && burst_i.cnt != 2'd0) |=> (out_valid_o && pos_q == 2'd0))
    else $error("loaded burst not presented from its first word");

endmodule
